/* src/csv_record_field_splitter_assert.svh */
// Assertion macros for the CSV splitter modules; the parser uses them.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CSV_RECORD_FIELD_SPLITTER_ASSERT_SVH
`define CSV_RECORD_FIELD_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csvs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csvs assertion failed");

`endif

/* src/csvs_pkg.sv */
// Package for the CSV record and field splitter: character codes, error codes,
// parser state and result types. No dependencies.
package csvs_pkg;

	localparam logic [7:0] QUOTE_CH = 8'h22;
	localparam logic [7:0] LF_CH = 8'h0A;
	localparam logic [7:0] CR_CH = 8'h0D;
	localparam logic [7:0] NUL_CH = 8'h00;
	localparam logic [7:0] DELIM_RESET = 8'h2C;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_NUL = 2'd1,
		ERR_OPEN_QUOTE = 2'd2
	} err_t;

	typedef struct packed {
		logic quoted;
		logic quote_pending;
		logic swallow_lf;
		logic record_started;
		logic halted;
	} parse_state_t;

	typedef struct packed {
		logic has_byte;
		logic [7:0] out_byte;
		logic field_end;
		logic record_end;
		err_t error_code;
		logic last;
	} result_t;

	typedef struct packed {
		logic emit;
		result_t res;
	} step_out_t;

endpackage

/* src/csvs_if.sv */
// Valid/ready channel interfaces for the CSV splitter's input and result streams.
// Depends on nothing; payload signals carry the field names of each stream.
interface csvs_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [7:0] in_byte;

	modport source(output valid, mode, in_byte, input ready);
	modport sink(input valid, mode, in_byte, output ready);
endinterface

interface csvs_out_if;
	logic valid;
	logic ready;
	logic has_byte;
	logic [7:0] out_byte;
	logic field_end;
	logic record_end;
	logic [1:0] error_code;
	logic last;

	modport source(output valid, has_byte, out_byte, field_end, record_end, error_code, last,
		input ready);
	modport sink(input valid, has_byte, out_byte, field_end, record_end, error_code, last,
		output ready);
endinterface

/* src/csvs_in_stage.sv */
// Input register stage of the CSV splitter: holds one accepted request.
// Depends on nothing beyond the clock and reset.
module csvs_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_mode,
	input  logic [7:0] in_data,
	input  logic       advance,
	output logic       valid_s1,
	output logic       mode_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= in_mode;
			byte_s1 <= in_data;
		end
	end

endmodule

/* src/csvs_parser.sv */
// Parser of the CSV splitter: quoting and line-break state, delimiter register,
// and the per-byte result decision. Depends on csvs_pkg and the assertion header.
`include "csv_record_field_splitter_assert.svh"

module csvs_parser
	import csvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       advance,
	input  logic       mode_s1,
	input  logic [7:0] byte_s1,
	output step_out_t  step
);

	parse_state_t st_q;
	parse_state_t st_d;
	logic [7:0] delim_q;
	logic unquoted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_we) begin
			delim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unquoted = 1'b0;
		step.emit = 1'b0;
		step.res.has_byte = 1'b0;
		step.res.out_byte = '0;
		step.res.field_end = 1'b0;
		step.res.record_end = 1'b0;
		step.res.error_code = ERR_NONE;
		step.res.last = 1'b1;
		if (st_q.halted) begin
			st_d = st_q;
		end else if (mode_s1) begin
			if (st_q.quoted && !st_q.quote_pending) begin
				st_d.halted = 1'b1;
				step.emit = 1'b1;
				step.res.error_code = ERR_OPEN_QUOTE;
			end else begin
				st_d = '0;
				if (st_q.record_started) begin
					step.emit = 1'b1;
					step.res.field_end = 1'b1;
					step.res.record_end = 1'b1;
				end
			end
		end else if (byte_s1 == NUL_CH) begin
			st_d.halted = 1'b1;
			step.emit = 1'b1;
			step.res.error_code = ERR_NUL;
		end else begin
			st_d.swallow_lf = 1'b0;
			if (!(st_q.swallow_lf && byte_s1 == LF_CH)) begin
				if (st_q.quote_pending) begin
					st_d.quote_pending = 1'b0;
					if (byte_s1 == QUOTE_CH) begin
						step.emit = 1'b1;
						step.res.has_byte = 1'b1;
						step.res.out_byte = QUOTE_CH;
					end else begin
						st_d.quoted = 1'b0;
						unquoted = 1'b1;
					end
				end else if (st_q.quoted) begin
					if (byte_s1 == QUOTE_CH) begin
						st_d.quote_pending = 1'b1;
					end else begin
						step.emit = 1'b1;
						step.res.has_byte = 1'b1;
						step.res.out_byte = byte_s1;
					end
				end else begin
					unquoted = 1'b1;
				end
				if (unquoted) begin
					if (byte_s1 == QUOTE_CH) begin
						st_d.quoted = 1'b1;
						st_d.record_started = 1'b1;
					end else if (byte_s1 == LF_CH || byte_s1 == CR_CH) begin
						st_d.swallow_lf = (byte_s1 == CR_CH);
						if (st_q.record_started) begin
							st_d.record_started = 1'b0;
							step.emit = 1'b1;
							step.res.field_end = 1'b1;
							step.res.record_end = 1'b1;
						end
					end else begin
						st_d.record_started = 1'b1;
						step.emit = 1'b1;
						if (byte_s1 == delim_q) begin
							step.res.field_end = 1'b1;
						end else begin
							step.res.has_byte = 1'b1;
							step.res.out_byte = byte_s1;
						end
					end
				end
			end
		end
	end

	`CSVS_ASSERT_NEXT(a_halt_sticks, st_q.halted, st_q.halted)
	`CSVS_ASSERT_NEXT(a_error_halts, advance && step.emit && step.res.error_code != ERR_NONE,
		st_q.halted)
	`CSVS_ASSERT_NOW(a_byte_no_marks, step.emit && step.res.has_byte,
		!step.res.field_end && !step.res.record_end)
	`CSVS_ASSERT_NOW(a_record_ends_field, step.emit && step.res.record_end, step.res.field_end)

endmodule

/* src/csvs_out_stage.sv */
// Result register of the CSV splitter: holds one result until the receiver takes it.
// Depends on csvs_pkg for the result type.
module csvs_out_stage
	import csvs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  step_out_t step,
	input  logic      load,
	input  logic      out_ready,
	output logic      out_free,
	output logic      out_valid,
	output result_t   res_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load && step.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load && step.emit) begin
			res_q <= step.res;
		end
	end

endmodule

/* src/csv_record_field_splitter.sv */
// CSV record and field splitter, top level.
// Requests arrive on in_ch: mode 0 carries one raw byte in in_byte, mode 1 marks the
// end of the input stream. Results leave on out_ch: a content byte
// (has_byte), an end-of-field mark, an end-of-record mark, or an error code.
// The user writes the field delimiter through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. Each request yields at most
// one result. Quotes opening quoting, the first quote of a doubled pair,
// swallowed linefeeds after CR, empty lines and the closing quote give no result.
// An accepted request is held in the input register; the combinational parser step
// then feeds the result register, which loads it once the result register is free.
// Throughput is one request per cycle while results are taken; the single parser
// step between the input register and the result register sets that figure.
// A stalled receiver holds the result register; the input register then fills and
// in_ch.ready drops until the result is taken.
// Reset clears all parse state, the error halt and both registers' valid bits, and
// restores the comma delimiter. After a NUL byte or an open quote at end of input
// the block halts: requests are still accepted but give no result until reset.
module csv_record_field_splitter
	import csvs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	csvs_in_if.sink        in_ch,
	csvs_out_if.source     out_ch,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata
);

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;
	step_out_t  step;
	result_t    res_q;

	assign advance = valid_s1 && out_free;

	csvs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_mode  (in_ch.mode),
		.in_data  (in_ch.in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.mode_s1  (mode_s1),
		.byte_s1  (byte_s1)
	);

	csvs_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.mode_s1   (mode_s1),
		.byte_s1   (byte_s1),
		.step      (step)
	);

	csvs_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.load      (advance),
		.out_ready (out_ch.ready),
		.out_free  (out_free),
		.out_valid (out_ch.valid),
		.res_q     (res_q)
	);

	assign out_ch.has_byte = res_q.has_byte;
	assign out_ch.out_byte = res_q.out_byte;
	assign out_ch.field_end = res_q.field_end;
	assign out_ch.record_end = res_q.record_end;
	assign out_ch.error_code = res_q.error_code;
	assign out_ch.last = res_q.last;

endmodule

/* tb/sv/csv_token_checker.sv */
// Result checker for the CSV record and field splitter: watches both channels and the
// delimiter write port, predicts each result, and compares it in order.
// Depends on csvs_pkg and on the csvs_in_if and csvs_out_if interfaces.
module csv_token_checker
	import csvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	csvs_in_if         in_ch,
	csvs_out_if        out_ch,
	output int         fail_count,
	output int         pending,
	output int         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] delim;
	logic quote_open;
	logic quote_lookahead;
	logic skip_lf;
	logic record_open;
	logic stopped;

	result_t expected_tokens[$];
	result_t seen;
	result_t want;
	result_t token;
	logic token_valid;

	function automatic result_t make_token(input logic hb, input logic [7:0] b,
			input logic fe, input logic re, input err_t err);
		result_t r;
		r.has_byte = hb;
		r.out_byte = hb ? b : 8'h00;
		r.field_end = fe;
		r.record_end = re;
		r.error_code = err;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic clear_parse();
		quote_open = 1'b0;
		quote_lookahead = 1'b0;
		skip_lf = 1'b0;
		record_open = 1'b0;
	endtask

	task automatic tokenize_byte(input logic m, input logic [7:0] c, output logic emit,
			output result_t r);
		emit = 1'b0;
		r = make_token(1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		if (stopped) return;
		if (m) begin
			if (quote_lookahead) begin
				quote_lookahead = 1'b0;
				quote_open = 1'b0;
			end
			if (quote_open) begin
				stopped = 1'b1;
				emit = 1'b1;
				r = make_token(1'b0, 8'h00, 1'b0, 1'b0, ERR_OPEN_QUOTE);
				return;
			end
			if (record_open) begin
				emit = 1'b1;
				r = make_token(1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE);
			end
			clear_parse();
			return;
		end
		if (c == NUL_CH) begin
			stopped = 1'b1;
			emit = 1'b1;
			r = make_token(1'b0, 8'h00, 1'b0, 1'b0, ERR_NUL);
			return;
		end
		if (skip_lf) begin
			skip_lf = 1'b0;
			if (c == LF_CH) return;
		end
		if (quote_lookahead) begin
			quote_lookahead = 1'b0;
			if (c == QUOTE_CH) begin
				emit = 1'b1;
				r = make_token(1'b1, QUOTE_CH, 1'b0, 1'b0, ERR_NONE);
				return;
			end
			quote_open = 1'b0;
		end else if (quote_open) begin
			if (c == QUOTE_CH) begin
				quote_lookahead = 1'b1;
				return;
			end
			emit = 1'b1;
			r = make_token(1'b1, c, 1'b0, 1'b0, ERR_NONE);
			return;
		end
		if (c == QUOTE_CH) begin
			quote_open = 1'b1;
			record_open = 1'b1;
			return;
		end
		if (c == LF_CH || c == CR_CH) begin
			skip_lf = (c == CR_CH);
			if (!record_open) return;
			record_open = 1'b0;
			emit = 1'b1;
			r = make_token(1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE);
			return;
		end
		record_open = 1'b1;
		emit = 1'b1;
		if (c == delim) r = make_token(1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE);
		else r = make_token(1'b1, c, 1'b0, 1'b0, ERR_NONE);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim = DELIM_RESET;
			clear_parse();
			stopped = 1'b0;
			expected_tokens.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				seen.has_byte = out_ch.has_byte;
				seen.out_byte = out_ch.out_byte;
				seen.field_end = out_ch.field_end;
				seen.record_end = out_ch.record_end;
				seen.error_code = err_t'(out_ch.error_code);
				seen.last = out_ch.last;
				if (expected_tokens.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result hb=%b byte=%h fe=%b re=%b err=%0d last=%b",
							$realtime, seen.has_byte, seen.out_byte, seen.field_end,
							seen.record_end, seen.error_code, seen.last);
					fail_count++;
				end else begin
					want = expected_tokens.pop_front();
					checked++;
					if (seen !== want) begin
						if (fail_count < 10) begin
							$display("%0t: expected hb=%b byte=%h fe=%b re=%b err=%0d last=%b",
								$realtime, want.has_byte, want.out_byte, want.field_end,
								want.record_end, want.error_code, want.last);
							$display("%0t:   actual hb=%b byte=%h fe=%b re=%b err=%0d last=%b",
								$realtime, seen.has_byte, seen.out_byte, seen.field_end,
								seen.record_end, seen.error_code, seen.last);
						end
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				tokenize_byte(in_ch.mode, in_ch.in_byte, token_valid, token);
				if (token_valid) expected_tokens = {expected_tokens, token};
			end
			if (cfg_we) delim = cfg_wdata;
			pending = expected_tokens.size();
		end
	end

endmodule

/* tb/sv/csv_record_field_splitter_test.sv */
// Top of the CSV splitter testbench: clock, reset, byte stream stimulus under eight
// delimiter settings, and the verdict. Depends on csvs_pkg, the channel interfaces,
// the splitter itself and csv_token_checker.
module csv_record_field_splitter_test;
	import csvs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_END = 1'b1;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 230;
	localparam logic [7:0] COMMA = 8'h2C;
	localparam logic [7:0] TAB = 8'h09;

	localparam logic [8:0] DIRECTED [0:23] = '{
		{MODE_BYTE, 8'h61}, {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'hFF}, {MODE_BYTE, COMMA},
		{MODE_BYTE, QUOTE_CH}, {MODE_BYTE, COMMA}, {MODE_BYTE, CR_CH}, {MODE_BYTE, LF_CH},
		{MODE_BYTE, QUOTE_CH}, {MODE_BYTE, QUOTE_CH}, {MODE_BYTE, QUOTE_CH},
		{MODE_BYTE, 8'h62}, {MODE_BYTE, CR_CH}, {MODE_BYTE, LF_CH}, {MODE_BYTE, LF_CH},
		{MODE_BYTE, CR_CH}, {MODE_BYTE, 8'h63}, {MODE_BYTE, QUOTE_CH}, {MODE_BYTE, 8'h64},
		{MODE_BYTE, QUOTE_CH}, {MODE_BYTE, 8'h65}, {MODE_BYTE, COMMA}, {MODE_END, 8'hA5},
		{MODE_END, 8'h00}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	csvs_in_if in_ch();
	csvs_out_if out_ch();

	int fail_count;
	int pending;
	int checked;
	int idle_cycles = 0;
	int sent = 0;
	int phase_sent = 0;
	int streams = 0;
	logic calm = 1'b0;
	logic quote_odd = 1'b0;
	logic nul_end;
	logic [7:0] cur_delim = DELIM_RESET;

	csv_record_field_splitter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	csv_token_checker i_token_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("csv_record_field_splitter verification failed");
			$finish;
		end
	end

	task automatic send_request(input logic m, input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 18) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		sent++;
		phase_sent++;
		if (m == MODE_END) quote_odd = 1'b0;
		else if (b == QUOTE_CH) quote_odd = !quote_odd;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_delimiter(input logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_delim = v;
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] content_byte();
		logic [7:0] v;
		do begin
			if ($urandom_range(0, 1)) v = 8'($urandom_range(8'h61, 8'h7A));
			else v = any_byte();
		end while (v == QUOTE_CH || v == CR_CH || v == LF_CH || v == cur_delim);
		return v;
	endfunction

	function automatic logic [7:0] sep_byte();
		return (cur_delim == NUL_CH) ? COMMA : cur_delim;
	endfunction

	task automatic line_break();
		case ($urandom_range(0, 2))
			0: send_request(MODE_BYTE, LF_CH);
			1: send_request(MODE_BYTE, CR_CH);
			default: begin
				send_request(MODE_BYTE, CR_CH);
				send_request(MODE_BYTE, LF_CH);
			end
		endcase
	endtask

	task automatic push_field();
		int len;
		logic [7:0] v;
		len = $urandom_range(0, 6);
		if ($urandom_range(0, 99) < 30) begin
			send_request(MODE_BYTE, QUOTE_CH);
			repeat (len) begin
				v = any_byte();
				send_request(MODE_BYTE, v);
				if (v == QUOTE_CH) send_request(MODE_BYTE, QUOTE_CH);
			end
			send_request(MODE_BYTE, QUOTE_CH);
		end else begin
			repeat (len) send_request(MODE_BYTE, content_byte());
		end
	endtask

	task automatic push_record();
		int nf;
		nf = $urandom_range(1, 5);
		for (int i = 0; i < nf; i++) begin
			if (i > 0) send_request(MODE_BYTE, sep_byte());
			push_field();
		end
		if ($urandom_range(0, 9) != 0) line_break();
		if ($urandom_range(0, 9) == 0) line_break();
	endtask

	task automatic push_noise();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 4))
				0: send_request(MODE_BYTE, QUOTE_CH);
				1: send_request(MODE_BYTE, CR_CH);
				2: send_request(MODE_BYTE, LF_CH);
				3: send_request(MODE_BYTE, sep_byte());
				default: send_request(MODE_BYTE, any_byte());
			endcase
		end
	endtask

	task automatic end_stream();
		if (quote_odd) send_request(MODE_BYTE, QUOTE_CH);
		send_request(MODE_END, 8'($urandom_range(0, 255)));
		streams++;
	endtask

	task automatic run_phase(input logic [7:0] v, input logic steady);
		logic held;
		held = 1'b0;
		set_delimiter(v);
		calm = steady;
		phase_sent = 0;
		while (phase_sent < PHASE_ITEMS) begin
			if ($urandom_range(0, 99) < 85) push_record();
			else push_noise();
			if ($urandom_range(0, 99) < 15) end_stream();
			if (!held && phase_sent > PHASE_ITEMS / 2) begin
				held = 1'b1;
				drain();
			end
		end
		end_stream();
		calm = 1'b0;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_BYTE;
		in_ch.in_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) send_request(DIRECTED[i][8], DIRECTED[i][7:0]);

		run_phase(DELIM_RESET, 1'b1);
		run_phase(NUL_CH, 1'b0);
		run_phase(8'hFF, 1'b0);
		run_phase(QUOTE_CH, 1'b0);
		run_phase(CR_CH, 1'b0);
		run_phase(LF_CH, 1'b0);
		run_phase(TAB, 1'b0);
		run_phase(any_byte(), 1'b0);

		drain();
		nul_end = 1'($urandom_range(0, 1));
		if (nul_end) begin
			send_request(MODE_BYTE, 8'h71);
			send_request(MODE_BYTE, NUL_CH);
			send_request(MODE_BYTE, QUOTE_CH);
			send_request(MODE_END, 8'h00);
		end else begin
			send_request(MODE_BYTE, QUOTE_CH);
			send_request(MODE_BYTE, 8'h78);
			send_request(MODE_END, 8'h00);
			send_request(MODE_BYTE, NUL_CH);
			send_request(MODE_END, 8'h00);
		end
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);

		$display("Sent %0d requests in %0d streams under eight delimiter settings; %0d results compared.",
			sent, streams, checked);
		$display("The run closed on the %s error, then confirmed the halted parser stays silent.",
			nul_end ? "NUL byte" : "open quote");
		if (fail_count == 0 && pending == 0) begin
			$display("csv_record_field_splitter verification clean");
		end else begin
			$display("csv_record_field_splitter verification failed");
		end
		$finish;
	end

endmodule
